### src/gbsp_pkg.sv
// ----------------------------------------------------------------------------
// gbsp_pkg
// Shared types and constants of the grid breadth-first path finder.
// ----------------------------------------------------------------------------
package gbsp_pkg;

  localparam int unsigned DEF_MAX_COLS = 128;
  localparam int unsigned DEF_MAX_ROWS = 128;

  // Grid dimensions up to 1024 need 11 bits, coordinates need 10.
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned CRD_W     = 10;
  localparam int unsigned LEN_W     = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FIND  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_START_COL   = 3'd2,
    CFG_START_ROW   = 3'd3,
    CFG_END_COL     = 3'd4,
    CFG_END_ROW     = 3'd5
  } cfg_idx_t;

  // Direction from a cell to its parent.
  typedef enum logic [1:0] {
    DIR_WEST  = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_NORTH = 2'd2,
    DIR_SOUTH = 2'd3
  } dir_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [6:0] cell_col;
    logic [6:0] cell_row;
    logic       cell_open;
  } in_item_t;

  typedef struct packed {
    logic             reachable;
    logic [LEN_W-1:0] path_length;
    logic             on_path;
    logic             is_open;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } cmd_t;

  // Clamped search geometry.
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [CRD_W-1:0] sc;
    logic [CRD_W-1:0] sr;
    logic [CRD_W-1:0] ec;
    logic [CRD_W-1:0] er;
  } geom_t;

  typedef struct packed {
    logic      busy;
    logic      valid;
    out_item_t item;
  } sts_t;

  typedef struct packed {
    logic open;
    logic visited;
    dir_t parent;
    logic path;
  } cell_word_t;

  localparam int unsigned CELL_W = 5;

endpackage

### src/gbsp_ram.sv
// ----------------------------------------------------------------------------
// gbsp_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module gbsp_ram
  import gbsp_pkg::*;
#(
  parameter int unsigned DATA_W = CELL_W,
  parameter int unsigned ADDR_W = 14
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [0:(1<<ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/gbsp_search.sv
// ----------------------------------------------------------------------------
// gbsp_search
// Command sequencer: cell reads and writes, the clearing sweep, the
// breadth-first search over the cell memory and queue, and the traceback.
// ----------------------------------------------------------------------------
module gbsp_search
  import gbsp_pkg::*;
#(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  geom_t geom,
  output sts_t  sts
);

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned AW = CW + RW;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_WRC     = 14'b00000000000010,
    S_RDC     = 14'b00000000000100,
    S_CLR     = 14'b00000000001000,
    S_SEED_RD = 14'b00000000010000,
    S_SEED_WR = 14'b00000000100000,
    S_POP     = 14'b00000001000000,
    S_POP_W   = 14'b00000010000000,
    S_CHK     = 14'b00000100000000,
    S_NB      = 14'b00001000000000,
    S_NB_W    = 14'b00010000000000,
    S_T_RD    = 14'b00100000000000,
    S_T_STEP  = 14'b01000000000000,
    S_FIN     = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0]     c_wr_addr, c_rd_addr, q_wr_addr, q_rd_addr;
  logic              c_wr_en, c_rd_en, q_wr_en, q_rd_en;
  logic [CELL_W-1:0] c_wr_data, c_rd_data;
  logic [AW-1:0]     q_wr_data, q_rd_data;
  cell_word_t        word, word_mod;

  logic [AW-1:0]     op_addr, clr_wa;
  logic              op_inside, op_write, op_open;
  logic [CW-1:0]     cur_c, nb_c, nb_c_n, tr_c, tr_c_n;
  logic [RW-1:0]     cur_r, nb_r, nb_r_n, tr_r, tr_r_n;
  dir_t              dir, back;
  logic [1:0]        dir_inc;
  logic              nb_ok, enq;
  logic [AW:0]       head, tail, clr_addr;
  logic              clr_pend, found, searched;
  logic [LEN_W-1:0]  len;
  logic              res_on, res_open, res_valid;

  logic [AW-1:0]     in_addr, s_addr;
  logic              in_inside;
  logic [CRD_W-1:0]  in_col, in_row;

  assign in_col    = CRD_W'(cmd.item.cell_col);
  assign in_row    = CRD_W'(cmd.item.cell_row);
  assign in_inside = (DIM_W'(cmd.item.cell_col) < DIM_W'(MAX_COLS)) &&
                     (DIM_W'(cmd.item.cell_row) < DIM_W'(MAX_ROWS));
  assign in_addr   = {in_row[RW-1:0], in_col[CW-1:0]};
  assign s_addr    = {geom.sr[RW-1:0], geom.sc[CW-1:0]};
  assign word      = cell_word_t'(c_rd_data);
  assign dir_inc   = dir + 2'd1;

  gbsp_ram #(.DATA_W(CELL_W), .ADDR_W(AW)) u_cell_ram (
    .clk     (clk),
    .wr_en   (c_wr_en),
    .wr_addr (c_wr_addr),
    .wr_data (c_wr_data),
    .rd_en   (c_rd_en),
    .rd_addr (c_rd_addr),
    .rd_data (c_rd_data)
  );

  gbsp_ram #(.DATA_W(AW), .ADDR_W(AW)) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (q_wr_addr),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .rd_data (q_rd_data)
  );

  // Neighbor of the current cell in the direction under test.
  always_comb begin
    nb_c_n = cur_c;
    nb_r_n = cur_r;
    nb_ok  = 1'b0;
    back   = DIR_EAST;
    case (dir)
      DIR_WEST: begin
        nb_ok  = (cur_c != '0);
        nb_c_n = cur_c - CW'(1);
        back   = DIR_EAST;
      end
      DIR_EAST: begin
        nb_ok  = (DIM_W'(cur_c) + DIM_W'(1)) < geom.w;
        nb_c_n = cur_c + CW'(1);
        back   = DIR_WEST;
      end
      DIR_NORTH: begin
        nb_ok  = (cur_r != '0);
        nb_r_n = cur_r - RW'(1);
        back   = DIR_SOUTH;
      end
      default: begin
        nb_ok  = (DIM_W'(cur_r) + DIM_W'(1)) < geom.h;
        nb_r_n = cur_r + RW'(1);
        back   = DIR_NORTH;
      end
    endcase
  end

  // Step of the traceback along the stored parent direction.
  always_comb begin
    tr_c_n = tr_c;
    tr_r_n = tr_r;
    case (word.parent)
      DIR_WEST:  tr_c_n = tr_c - CW'(1);
      DIR_EAST:  tr_c_n = tr_c + CW'(1);
      DIR_NORTH: tr_r_n = tr_r - RW'(1);
      default:   tr_r_n = tr_r + RW'(1);
    endcase
  end

  always_comb begin
    state_next = state;
    c_rd_en    = 1'b0;
    c_rd_addr  = op_addr;
    c_wr_en    = 1'b0;
    c_wr_addr  = op_addr;
    word_mod   = word;
    q_rd_en    = 1'b0;
    q_rd_addr  = head[AW-1:0];
    q_wr_en    = 1'b0;
    q_wr_addr  = tail[AW-1:0];
    q_wr_data  = {nb_r, nb_c};
    enq        = 1'b0;
    res_on     = 1'b0;
    res_open   = 1'b0;
    res_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          case (cmd.item.opcode)
            OP_FIND: state_next = S_CLR;
            OP_READ: begin
              c_rd_en    = 1'b1;
              c_rd_addr  = in_addr;
              state_next = S_RDC;
            end
            default: begin
              c_rd_en    = 1'b1;
              c_rd_addr  = in_addr;
              state_next = S_WRC;
            end
          endcase
        end
      end
      S_WRC: begin
        c_wr_en       = op_write;
        word_mod.open = op_open;
        res_valid     = 1'b1;
        state_next    = S_IDLE;
      end
      S_RDC: begin
        res_on     = op_inside & word.path & searched;
        res_open   = op_inside & word.open;
        res_valid  = 1'b1;
        state_next = S_IDLE;
      end
      S_CLR: begin
        c_rd_en          = !clr_addr[AW];
        c_rd_addr        = clr_addr[AW-1:0];
        c_wr_en          = clr_pend;
        c_wr_addr        = clr_wa;
        word_mod.visited = 1'b0;
        word_mod.path    = 1'b0;
        if (clr_addr[AW]) begin
          state_next = S_SEED_RD;
        end
      end
      S_SEED_RD: begin
        c_rd_en    = 1'b1;
        c_rd_addr  = s_addr;
        q_wr_en    = 1'b1;
        q_wr_addr  = '0;
        q_wr_data  = s_addr;
        state_next = S_SEED_WR;
      end
      S_SEED_WR: begin
        c_wr_en          = 1'b1;
        c_wr_addr        = s_addr;
        word_mod.visited = 1'b1;
        state_next       = S_POP;
      end
      S_POP: begin
        if (head == tail) begin
          state_next = S_T_RD;
        end else begin
          q_rd_en    = 1'b1;
          state_next = S_POP_W;
        end
      end
      S_POP_W: begin
        c_rd_en    = 1'b1;
        c_rd_addr  = q_rd_data;
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = word.open ? S_NB : S_POP;
      end
      S_NB: begin
        if (nb_ok) begin
          c_rd_en    = 1'b1;
          c_rd_addr  = {nb_r_n, nb_c_n};
          state_next = S_NB_W;
        end else if (dir == DIR_SOUTH) begin
          state_next = S_POP;
        end
      end
      S_NB_W: begin
        enq              = word.open && !word.visited;
        c_wr_en          = enq;
        c_wr_addr        = {nb_r, nb_c};
        word_mod.visited = 1'b1;
        word_mod.parent  = back;
        q_wr_en          = enq;
        state_next       = (dir == DIR_SOUTH) ? S_POP : S_NB;
      end
      S_T_RD: begin
        c_rd_en    = 1'b1;
        c_rd_addr  = {tr_r, tr_c};
        state_next = S_T_STEP;
      end
      S_T_STEP: begin
        if (!word.visited) begin
          state_next = S_FIN;
        end else begin
          c_wr_en       = 1'b1;
          c_wr_addr     = {tr_r, tr_c};
          word_mod.path = 1'b1;
          state_next    = ({tr_r, tr_c} == s_addr) ? S_FIN : S_T_RD;
        end
      end
      S_FIN: begin
        res_valid  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign c_wr_data            = CELL_W'(word_mod);
  assign sts.busy             = (state != S_IDLE);
  assign sts.valid            = res_valid;
  assign sts.item.reachable   = found;
  assign sts.item.path_length = len;
  assign sts.item.on_path     = res_on;
  assign sts.item.is_open     = res_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      found    <= 1'b0;
      len      <= '0;
      searched <= 1'b0;
      head     <= '0;
      tail     <= '0;
      clr_addr <= '0;
      clr_pend <= 1'b0;
      dir      <= DIR_WEST;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_addr   <= in_addr;
            op_inside <= in_inside;
            op_write  <= in_inside && (cmd.item.opcode == OP_WRITE);
            op_open   <= cmd.item.cell_open;
            clr_addr  <= '0;
            clr_pend  <= 1'b0;
          end
        end
        S_CLR: begin
          clr_pend <= !clr_addr[AW];
          clr_wa   <= clr_addr[AW-1:0];
          if (!clr_addr[AW]) begin
            clr_addr <= clr_addr + 1'b1;
          end else begin
            found    <= 1'b0;
            len      <= '0;
            searched <= 1'b1;
            head     <= '0;
            tr_c     <= geom.ec[CW-1:0];
            tr_r     <= geom.er[RW-1:0];
          end
        end
        S_SEED_RD: tail <= (AW+1)'(1);
        S_POP: begin
          if (head != tail) begin
            head <= head + 1'b1;
          end
        end
        S_POP_W: begin
          cur_c <= q_rd_data[CW-1:0];
          cur_r <= q_rd_data[AW-1:CW];
        end
        S_CHK: dir <= DIR_WEST;
        S_NB: begin
          if (nb_ok) begin
            nb_c <= nb_c_n;
            nb_r <= nb_r_n;
          end else if (dir != DIR_SOUTH) begin
            dir <= dir_t'(dir_inc);
          end
        end
        S_NB_W: begin
          if (enq) begin
            tail <= tail + 1'b1;
          end
          if (dir != DIR_SOUTH) begin
            dir <= dir_t'(dir_inc);
          end
        end
        S_T_STEP: begin
          if (word.visited) begin
            found <= 1'b1;
            if (len != LEN_MAX) begin
              len <= len + 1'b1;
            end
            tr_c <= tr_c_n;
            tr_r <= tr_r_n;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### src/grid_bfs_shortest_path_top.sv
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path_top
// Grid map store with breadth-first shortest path search and path readout.
// ----------------------------------------------------------------------------
// Usage:
// The command channel (cmd_valid, cmd_stall, cmd_data) carries one command
// per transfer: write a cell's open bit, find a path, or read a cell. Every
// command yields exactly one result transfer on the response channel
// (rsp_valid, rsp_stall, rsp_data) holding the last search outcome and, for
// reads, the cell's path and open bits. The configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) sets grid size and end points
// and is always ready; write it only while the block is idle.
// A write or read passes from the idle state to its write or read state,
// which delivers the result and returns to idle; no new command is taken
// before that. A find first sweeps the cell memory (one entry per cycle),
// then for each dequeued cell reads the queue and the cell, reads each
// neighbor looked at and queues it if open and unvisited, then reads and
// marks each path cell. The command channel is stalled for the whole find.
// Reset returns the registers to their defaults and marks the path map as
// empty; the cell memory itself is not cleared. While the response register
// is full and stalled, no new command is taken.
// ----------------------------------------------------------------------------
module grid_bfs_shortest_path_top
  import gbsp_pkg::*;
#(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  in_item_t             cmd_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output out_item_t            rsp_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // Configuration registers.
  logic [7:0] grid_width, grid_height;
  logic [6:0] start_col, start_row, end_col, end_row;

  cmd_t  cmd;
  geom_t geom;
  sts_t  sts;

  logic [DIM_W-1:0] w_raw, h_raw, w_cl, h_cl;
  logic [DIM_W-1:0] sc_cl, sr_cl, ec_cl, er_cl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 8'd15;
      grid_height <= 8'd15;
      start_col   <= 7'd0;
      start_row   <= 7'd0;
      end_col     <= 7'd14;
      end_row     <= 7'd14;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        CFG_START_COL:   start_col   <= cfg_data[6:0];
        CFG_START_ROW:   start_row   <= cfg_data[6:0];
        CFG_END_COL:     end_col     <= cfg_data[6:0];
        CFG_END_ROW:     end_row     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // A zero dimension acts as one and an oversized one as the storage size;
  // the end points are then pulled inside the grid. The user must only change
  // configuration while idle (the block does not enforce it) for this to settle.
  assign w_raw = DIM_W'(grid_width);
  assign h_raw = DIM_W'(grid_height);
  assign w_cl  = (w_raw == '0) ? DIM_W'(1) :
                 (w_raw > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : w_raw;
  assign h_cl  = (h_raw == '0) ? DIM_W'(1) :
                 (h_raw > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : h_raw;
  assign sc_cl = (DIM_W'(start_col) >= w_cl) ? w_cl - 1'b1 : DIM_W'(start_col);
  assign sr_cl = (DIM_W'(start_row) >= h_cl) ? h_cl - 1'b1 : DIM_W'(start_row);
  assign ec_cl = (DIM_W'(end_col) >= w_cl) ? w_cl - 1'b1 : DIM_W'(end_col);
  assign er_cl = (DIM_W'(end_row) >= h_cl) ? h_cl - 1'b1 : DIM_W'(end_row);

  assign geom.w  = w_cl;
  assign geom.h  = h_cl;
  assign geom.sc = sc_cl[CRD_W-1:0];
  assign geom.sr = sr_cl[CRD_W-1:0];
  assign geom.ec = ec_cl[CRD_W-1:0];
  assign geom.er = er_cl[CRD_W-1:0];

  // A command is taken only when the sequencer is idle and the response
  // register is free or being emptied in the same cycle, so its result
  // always finds room.
  assign cmd_stall = sts.busy || (rsp_valid && rsp_stall);
  assign cmd.valid = cmd_valid && !cmd_stall;
  assign cmd.item  = cmd_data;

  gbsp_search #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_search (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .geom (geom),
    .sts  (sts)
  );

  // Response register: holds one result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (sts.valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.valid) begin
      rsp_data <= sts.item;
    end
  end

  // A new result never overwrites one that is still held back.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    sts.valid |-> !(rsp_valid && rsp_stall))
    else $error("result produced while response register is stalled");

  // Every accepted command keeps the sequencer busy in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> sts.busy)
    else $error("sequencer not busy after command transfer");

  // The sequencer returns to idle right after it delivers a result.
  a_idle_after_result : assert property (@(posedge clk) disable iff (rst)
    sts.valid |=> !sts.busy)
    else $error("sequencer still busy after result");

endmodule

### verif/grid_bfs_shortest_path_checker.sv
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path_checker
// Watches the command, configuration and response channels of the grid path
// finder, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module grid_bfs_shortest_path_checker
  import gbsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  logic                 cmd_stall,
  input  in_item_t             cmd_data,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  out_item_t            rsp_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = 128;
  localparam int ROWS  = 128;
  localparam int CELLS = COLS * ROWS;

  logic [7:0] width_q, height_q;
  logic [6:0] start_col_q, start_row_q, end_col_q, end_row_q;

  bit         open_m [CELLS];
  bit         seen_m [CELLS];
  bit         path_m [CELLS];
  dir_t       par_m  [CELLS];
  int         frontier [CELLS];
  bit         found_q;
  logic [14:0] len_q;

  out_item_t  expected_rsp [$];

  function automatic int clamp_dim(int v, int maxv);
    return (v < 1) ? 1 : ((v > maxv) ? maxv : v);
  endfunction

  function automatic int clamp_crd(int v, int dim);
    return (v >= dim) ? dim - 1 : v;
  endfunction

  // Breadth-first flood from the start cell, then walk the parent links back
  // from the end cell and mark the path.
  function automatic void search_path();
    int w, h, s, e, head, tail, v, c, r, a, d, cur, steps;
    int   nb [4];
    bit   ok [4];
    dir_t back [4];
    w = clamp_dim(width_q, COLS);
    h = clamp_dim(height_q, ROWS);
    s = clamp_crd(start_row_q, h) * COLS + clamp_crd(start_col_q, w);
    e = clamp_crd(end_row_q, h) * COLS + clamp_crd(end_col_q, w);
    for (int i = 0; i < CELLS; i++) begin
      seen_m[i] = 1'b0;
      path_m[i] = 1'b0;
    end
    found_q = 1'b0;
    len_q   = '0;
    head = 0;
    tail = 0;
    seen_m[s] = 1'b1;
    frontier[tail++] = s;
    while (head < tail) begin
      v = frontier[head++];
      c = v % COLS;
      r = v / COLS;
      if (!open_m[v]) continue;
      ok[0] = c > 0;     nb[0] = v - 1;    back[0] = DIR_EAST;
      ok[1] = c + 1 < w; nb[1] = v + 1;    back[1] = DIR_WEST;
      ok[2] = r > 0;     nb[2] = v - COLS; back[2] = DIR_SOUTH;
      ok[3] = r + 1 < h; nb[3] = v + COLS; back[3] = DIR_NORTH;
      for (d = 0; d < 4; d++) begin
        if (!ok[d]) continue;
        a = nb[d];
        if (!open_m[a] || seen_m[a]) continue;
        seen_m[a] = 1'b1;
        par_m[a]  = back[d];
        if (tail < CELLS) frontier[tail++] = a;
      end
    end
    if (!seen_m[e]) return;
    found_q = 1'b1;
    cur   = e;
    steps = 0;
    forever begin
      path_m[cur] = 1'b1;
      if (len_q != LEN_MAX) len_q = len_q + 1'b1;
      if (cur == s || steps >= CELLS) break;
      steps++;
      case (par_m[cur])
        DIR_WEST:  cur = (cur % COLS != 0) ? cur - 1 : cur;
        DIR_EAST:  cur = (cur % COLS + 1 < COLS) ? cur + 1 : cur;
        DIR_NORTH: cur = (cur >= COLS) ? cur - COLS : cur;
        default:   cur = (cur + COLS < CELLS) ? cur + COLS : cur;
      endcase
    end
  endfunction

  function automatic out_item_t predict_response(in_item_t cmd);
    out_item_t res;
    int idx;
    idx = int'(cmd.cell_row) * COLS + int'(cmd.cell_col);
    res = '0;
    case (cmd.opcode)
      OP_WRITE: open_m[idx] = cmd.cell_open;
      OP_FIND:  search_path();
      OP_READ: begin
        res.on_path = path_m[idx];
        res.is_open = open_m[idx];
      end
      default: ;
    endcase
    res.reachable   = found_q;
    res.path_length = len_q;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst) begin
      width_q     <= 8'd15;
      height_q    <= 8'd15;
      start_col_q <= 7'd0;
      start_row_q <= 7'd0;
      end_col_q   <= 7'd14;
      end_row_q   <= 7'd14;
      for (int i = 0; i < CELLS; i++) path_m[i] = 1'b0;
      found_q    = 1'b0;
      len_q      = '0;
      fail_count = 0;
      expected_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_GRID_WIDTH:  width_q     <= cfg_data;
          CFG_GRID_HEIGHT: height_q    <= cfg_data;
          CFG_START_COL:   start_col_q <= cfg_data[6:0];
          CFG_START_ROW:   start_row_q <= cfg_data[6:0];
          CFG_END_COL:     end_col_q   <= cfg_data[6:0];
          CFG_END_ROW:     end_row_q   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (cmd_valid && !cmd_stall) expected_rsp.push_back(predict_response(cmd_data));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("response transfer with no command outstanding");
          fail_count++;
        end else begin
          exp_item = expected_rsp.pop_front();
          if (rsp_data.reachable !== exp_item.reachable) begin
            $error("reachable: expected %0d, got %0d", exp_item.reachable,
                   rsp_data.reachable);
            fail_count++;
          end
          if (rsp_data.path_length !== exp_item.path_length) begin
            $error("path_length: expected %0d, got %0d", exp_item.path_length,
                   rsp_data.path_length);
            fail_count++;
          end
          if (rsp_data.on_path !== exp_item.on_path) begin
            $error("on_path: expected %0d, got %0d", exp_item.on_path,
                   rsp_data.on_path);
            fail_count++;
          end
          if (rsp_data.is_open !== exp_item.is_open) begin
            $error("is_open: expected %0d, got %0d", exp_item.is_open,
                   rsp_data.is_open);
            fail_count++;
          end
        end
      end
    end
    pending = expected_rsp.size();
  end

endmodule

### verif/grid_bfs_shortest_path_top_test.sv
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path_top_test
// Drives map writes, path searches, cell reads and no-ops into the grid path
// finder over many grid settings, with random idling on both channels, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module grid_bfs_shortest_path_top_test;
  import gbsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 128;
  localparam int ROWS = 128;
  localparam int ITEM_GOAL = 1650;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_stall;
  in_item_t             cmd_data;
  logic                 rsp_valid;
  logic                 rsp_stall;
  out_item_t            rsp_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  int                   fail_count;
  int                   pending;

  // Transfer flags captured at the rising edge, read by the drivers at the
  // following falling edge, so no driver depends on event order at the edge.
  logic cmd_fire, cfg_fire;

  // Written cells; reads and searches only ever touch cells set here.
  bit   written_m [COLS*ROWS];
  int   n_items;
  // Calm turns idling off on both sides; hold_req asks the receiver for a
  // long stall so the response register fills and the command side backs up.
  bit   calm;
  bit   hold_req;
  int   grid_w, grid_h;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  grid_bfs_shortest_path_top uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  grid_bfs_shortest_path_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_data   (cmd_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_data   (rsp_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cmd_fire <= cmd_valid && !cmd_stall;
    cfg_fire <= cfg_valid && cfg_ready;
  end

  // The response side stalls at random. On request it holds stall high for a
  // long count of cycles while the command side keeps offering commands.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        rsp_stall <= !calm && ($urandom_range(99) < 24);
      end
    end
  end

  function automatic int clamp_dim(int v, int maxv);
    return (v < 1) ? 1 : ((v > maxv) ? maxv : v);
  endfunction

  // Offers one command and returns at the falling edge after its transfer.
  // Valid stays high afterwards so back-to-back commands need no gap; the
  // caller lowers it before it waits for the block to drain.
  task automatic send_cmd(opcode_t op, int col, int row, bit opn);
    while (!calm && $urandom_range(99) < 24) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_data  <= '{opcode: op, cell_col: 7'(col), cell_row: 7'(row), cell_open: opn};
    cmd_valid <= 1'b1;
    do begin
      @(posedge clk);
      @(negedge clk);
    end while (!cmd_fire);
    if (op == OP_WRITE) written_m[row*COLS + col] = 1'b1;
    n_items++;
  endtask

  // Waits for every outstanding response, then idles on for slack.
  task automatic drain();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk);
      @(negedge clk);
    end while (!cfg_fire);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_grid(int w, int h, int sc, int sr, int ec, int er);
    write_reg(CFG_GRID_WIDTH, 8'(w));
    write_reg(CFG_GRID_HEIGHT, 8'(h));
    write_reg(CFG_START_COL, 8'(sc));
    write_reg(CFG_START_ROW, 8'(sr));
    write_reg(CFG_END_COL, 8'(ec));
    write_reg(CFG_END_ROW, 8'(er));
    grid_w = clamp_dim(w, COLS);
    grid_h = clamp_dim(h, ROWS);
  endtask

  // Coordinate register value: half in the grid, half anywhere in 8 bits so
  // clamping and the ignored top bit get exercised.
  function automatic int pick_coord(int dim);
    return ($urandom_range(1) == 0) ? $urandom_range(dim - 1) : $urandom_range(255);
  endfunction

  // Reads only cells that were written: usually one inside the grid, else a
  // random cell anywhere if written, falling back on the origin.
  task automatic read_some_cell();
    int c, r;
    c = $urandom_range(grid_w - 1);
    r = $urandom_range(grid_h - 1);
    if ($urandom_range(99) < 25) begin
      c = $urandom_range(COLS - 1);
      r = $urandom_range(ROWS - 1);
      if (!written_m[r*COLS + c]) begin
        c = 0;
        r = 0;
      end
    end
    send_cmd(OP_READ, c, r, $urandom_range(1));
  endtask

  initial begin
    int w, h, k, sc, sr, ec, er;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_data  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    n_items   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed part on a 3x3 grid: open ring around a wall, corner to corner.
    set_grid(3, 3, 0, 0, 2, 2);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_cmd(OP_WRITE, c, r, !(c == 1 && r == 1));
    send_cmd(OP_FIND, 0, 0, 1'b0);
    send_cmd(OP_READ, 0, 0, 1'b0);
    send_cmd(OP_READ, 1, 0, 1'b0);
    send_cmd(OP_READ, 1, 1, 1'b0);
    send_cmd(OP_READ, 2, 2, 1'b0);
    // Unused opcode with every field bit set, then the far storage corner,
    // which lies outside the grid in use.
    send_cmd(OP_NOP, 127, 127, 1'b1);
    send_cmd(OP_WRITE, 127, 127, 1'b1);
    send_cmd(OP_READ, 127, 127, 1'b1);
    // Walled-in start: the end cannot be reached.
    send_cmd(OP_WRITE, 0, 0, 1'b0);
    send_cmd(OP_FIND, 0, 0, 1'b0);
    send_cmd(OP_READ, 2, 2, 1'b0);
    drain();
    // End equal to the wall start gives a one-cell path.
    write_reg(CFG_END_COL, 8'd0);
    write_reg(CFG_END_ROW, 8'd0);
    send_cmd(OP_FIND, 0, 0, 1'b0);
    send_cmd(OP_READ, 0, 0, 1'b0);
    drain();

    // Random phases: each sets a grid, fills every cell in use, then mixes
    // writes, reads, searches and the odd no-op.
    for (int phase = 0; n_items < ITEM_GOAL; phase++) begin
      k = $urandom_range(99);
      if (k < 6) begin
        w = ($urandom_range(1) != 0) ? 128 : 255;
        h = 1;
      end else if (k < 12) begin
        w = 1;
        h = ($urandom_range(1) != 0) ? 128 : 200;
      end else if (k < 16) begin
        w = 0;
        h = $urandom_range(1, 6);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end
      sc = pick_coord(clamp_dim(w, COLS));
      sr = pick_coord(clamp_dim(h, ROWS));
      ec = pick_coord(clamp_dim(w, COLS));
      er = pick_coord(clamp_dim(h, ROWS));
      set_grid(w, h, sc, sr, ec, er);
      calm = (phase == 3);
      if (phase == 5) hold_req = 1'b1;

      for (int r = 0; r < grid_h; r++)
        for (int c = 0; c < grid_w; c++)
          send_cmd(OP_WRITE, c, r, $urandom_range(99) < 70);
      // Mostly open end points so many searches find a path.
      if ($urandom_range(99) < 60) begin
        send_cmd(OP_WRITE, (sc % 128) >= grid_w ? grid_w - 1 : sc % 128,
                 (sr % 128) >= grid_h ? grid_h - 1 : sr % 128, 1'b1);
        send_cmd(OP_WRITE, (ec % 128) >= grid_w ? grid_w - 1 : ec % 128,
                 (er % 128) >= grid_h ? grid_h - 1 : er % 128, 1'b1);
      end
      send_cmd(OP_FIND, $urandom_range(127), $urandom_range(127), $urandom_range(1));

      for (int i = 0; i < 45; i++) begin
        k = $urandom_range(99);
        if (k < 40) begin
          if ($urandom_range(99) < 80)
            send_cmd(OP_WRITE, $urandom_range(grid_w - 1), $urandom_range(grid_h - 1),
                     $urandom_range(1));
          else
            send_cmd(OP_WRITE, $urandom_range(127), $urandom_range(127),
                     $urandom_range(1));
        end else if (k < 88) begin
          read_some_cell();
        end else if (k < 93) begin
          send_cmd(OP_NOP, $urandom_range(127), $urandom_range(127), $urandom_range(1));
        end else if (k < 96) begin
          send_cmd(OP_FIND, $urandom_range(127), $urandom_range(127), $urandom_range(1));
        end else begin
          // A run of reads right after a search walks the fresh path map.
          send_cmd(OP_FIND, 0, 0, 1'b0);
          for (int j = 0; j < 4; j++) read_some_cell();
        end
      end
      drain();
      calm = 1'b0;
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
src/gbsp_pkg.sv
src/gbsp_ram.sv
src/gbsp_search.sv
src/grid_bfs_shortest_path_top.sv
verif/grid_bfs_shortest_path_checker.sv
verif/grid_bfs_shortest_path_top_test.sv
